FILE: rtl/tpe_pkg.sv
// Shared types and constants for the TCP payload extractor.
// No dependencies; imported by every module of the block.
package tpe_pkg;

	// Default Ethernet header length in bytes (14 untagged, up to 22 with tags).
	localparam int EthHdrBytesDefault = 14;

	// Width of the saturating byte position counter.
	localparam int PosW = 17;

	// Smallest legal IP or TCP header, in 32-bit words.
	localparam logic [3:0] MinHdrWords = 4'd5;

	// TCP flag bits that are examined (FIN, SYN, PSH, ACK) and the wanted pattern.
	localparam logic [7:0] FlagMask = 8'h1B;
	localparam logic [7:0] FlagWant = 8'h18;

	// Offsets inside the IPv4 and TCP headers.
	localparam int IpLenHiOfs   = 2;
	localparam int IpLenLoOfs   = 3;
	localparam int TcpOffsetOfs = 12;
	localparam int TcpFlagsOfs  = 13;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_SHORT_IP  = 3'd1,
		ST_FLAGS     = 3'd2,
		ST_SHORT_TCP = 3'd3,
		ST_NEG_LEN   = 3'd4,
		ST_TRUNC     = 3'd5
	} status_t;

	// One result of the parser, ready for the output register.
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic       is_data;
		logic       is_final;
		status_t    status;
	} result_t;

endpackage

FILE: rtl/tpe_parse.sv
// Frame header parser: tracks the byte position and header fields of one frame
// and decides for each byte whether it is payload. Depends on tpe_pkg.
module tpe_parse #(
	parameter int ETH_HDR_BYTES = tpe_pkg::EthHdrBytesDefault
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        frame_byte,
	input  logic              frame_end,
	output tpe_pkg::result_t  result
);
	import tpe_pkg::*;

	localparam logic [PosW-1:0] Eth = PosW'(ETH_HDR_BYTES);

	logic [PosW-1:0] pos_q;
	logic [3:0]      ihw_q, ihw_n;
	logic [15:0]     len_q, len_n;
	logic [3:0]      thw_q, thw_n;
	logic [15:0]     left_q, left_n;
	status_t         err_q, err_n;

	logic [PosW-1:0] tcp_start, hdr_end, tcp_start_n;
	logic [5:0]      ip_b, tcp_b;
	logic [15:0]     hdr_sum;
	logic            emit;
	status_t         status;

	always_comb begin
		tcp_start   = Eth + PosW'({ihw_q, 2'b00});
		hdr_end     = tcp_start + PosW'({thw_q, 2'b00});
		ip_b        = {ihw_q, 2'b00};
		tcp_b       = {thw_q, 2'b00};
		hdr_sum     = 16'(ip_b) + 16'(tcp_b);
		ihw_n       = ihw_q;
		len_n       = len_q;
		thw_n       = thw_q;
		left_n      = left_q;
		err_n       = err_q;
		emit        = 1'b0;
		if (err_q == ST_OK) begin
			priority if (pos_q == Eth) begin
				ihw_n = frame_byte[3:0];
				if (frame_byte[3:0] < MinHdrWords)
					err_n = ST_SHORT_IP;
			end else if (pos_q == Eth + PosW'(IpLenHiOfs)) begin
				len_n[15:8] = frame_byte;
			end else if (pos_q == Eth + PosW'(IpLenLoOfs)) begin
				len_n[7:0] = frame_byte;
			end else if (pos_q > Eth) begin
				priority if (pos_q == tcp_start + PosW'(TcpOffsetOfs)) begin
					thw_n = frame_byte[7:4];
				end else if (pos_q == tcp_start + PosW'(TcpFlagsOfs)) begin
					priority if ((frame_byte & FlagMask) != FlagWant)
						err_n = ST_FLAGS;
					else if (thw_q < MinHdrWords)
						err_n = ST_SHORT_TCP;
					else if (len_q < hdr_sum)
						err_n = ST_NEG_LEN;
					else
						left_n = len_q - hdr_sum;
				end else if (pos_q > tcp_start + PosW'(TcpFlagsOfs) && pos_q >= hdr_end &&
						left_q != 16'd0) begin
					emit   = 1'b1;
					left_n = left_q - 16'd1;
				end else begin
				end
			end else begin
			end
		end

		// Status on the last byte uses the state as updated by this byte.
		tcp_start_n = Eth + PosW'({ihw_n, 2'b00});
		status      = ST_OK;
		if (frame_end) begin
			status = err_n;
			if (err_n == ST_OK &&
					(pos_q <= tcp_start_n + PosW'(TcpFlagsOfs) || left_n != 16'd0))
				status = ST_TRUNC;
		end

		result.valid    = emit | frame_end;
		result.data     = emit ? frame_byte : 8'd0;
		result.is_data  = emit;
		result.is_final = frame_end;
		result.status   = status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			ihw_q  <= '0;
			len_q  <= '0;
			thw_q  <= '0;
			left_q <= '0;
			err_q  <= ST_OK;
		end else if (accept) begin
			if (frame_end) begin
				pos_q  <= '0;
				ihw_q  <= '0;
				len_q  <= '0;
				thw_q  <= '0;
				left_q <= '0;
				err_q  <= ST_OK;
			end else begin
				if (pos_q != '1)
					pos_q <= pos_q + PosW'(1);
				ihw_q  <= ihw_n;
				len_q  <= len_n;
				thw_q  <= thw_n;
				left_q <= left_n;
				err_q  <= err_n;
			end
		end
	end

endmodule

FILE: rtl/tcp_payload_extractor.sv
// Top level of the TCP payload extractor: input handshake, parser and
// output register. Depends on tpe_pkg and tpe_parse.
//
// Usage:
// Raw Ethernet frame bytes enter on the input channel (frame_byte, with
// frame_end high on the last byte of each frame), one transaction per byte.
// A transaction completes on a rising edge of clk where its valid is high and
// its stall is low. The output channel carries the payload bytes of frames
// that pass the IPv4/TCP header checks (is_data high), and exactly one
// transaction for the last byte of every frame (is_final high) that carries
// the frame status. Apart from that final transaction, header bytes, link
// padding and the bytes of rejected frames give no output transaction.
// The result of a byte sits in the output register on the cycle after the
// byte was taken. Throughput is one byte per cycle while the receiver does
// not stall; the parser decides each byte with a few position compares and
// 16-bit subtracts, so nothing else in the design limits the rate below that.
// When the receiver stalls while the output register holds a result, the
// input is stalled in the same cycle and the held result stays unchanged; as
// soon as the result is taken a new byte is accepted in that very cycle.
// Reset (arst_n low) empties the output register and returns the parser to
// the start of a frame.
module tcp_payload_extractor #(
	parameter int ETH_HDR_BYTES = tpe_pkg::EthHdrBytesDefault
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] frame_byte,
	input  logic       frame_end,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] data_byte,
	output logic       is_data,
	output logic       is_final,
	output logic [2:0] frame_status
);
	import tpe_pkg::*;

	logic    accept;
	result_t result;
	logic    valid_s1;
	result_t result_s1;

	// The output register frees up whenever its content is taken, so a byte
	// can be accepted in the same cycle as a result leaves.
	assign in_stall = valid_s1 & out_stall;
	assign accept   = in_valid & ~in_stall;

	tpe_parse #(
		.ETH_HDR_BYTES(ETH_HDR_BYTES)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.frame_byte(frame_byte),
		.frame_end (frame_end),
		.result    (result)
	);

	// Valid of the output register is control state and is reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= accept & result.valid;
		end
	end

	// Payload of the output register loads with each result that is produced.
	always_ff @(posedge clk) begin
		if (accept && result.valid)
			result_s1 <= result;
	end

	assign out_valid    = valid_s1;
	assign data_byte    = result_s1.data;
	assign is_data      = result_s1.is_data;
	assign is_final     = result_s1.is_final;
	assign frame_status = result_s1.status;

endmodule

FILE: rtl/tpe_checker.sv
// Port-level checks for the TCP payload extractor, attached by bind.
// Depends on tpe_pkg and the tcp_payload_extractor port list.
module tpe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] data_byte,
	input logic       is_data,
	input logic       is_final,
	input logic [2:0] frame_status
);
	import tpe_pkg::*;

	// A result held by the receiver stays put.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(data_byte) && $stable(is_data) &&
			$stable(is_final) && $stable(frame_status))
		else $error("output changed while stalled");

	// Every result carries a payload byte or closes a frame.
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> is_data || is_final)
		else $error("empty result");

	// Data byte is zero unless it is payload.
	a_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_data |-> data_byte == 8'd0)
		else $error("data byte set without payload");

	// Status only on the last byte, and only a defined code.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_final || frame_status == 3'(ST_OK)) &&
			frame_status <= 3'(ST_TRUNC))
		else $error("bad frame status");

	// The input is held off only while a result waits for the receiver.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without cause");

endmodule

bind tcp_payload_extractor tpe_checker u_tpe_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.data_byte   (data_byte),
	.is_data     (is_data),
	.is_final    (is_final),
	.frame_status(frame_status)
);

FILE: verif/tb_top.sv
// Self-checking testbench for tcp_payload_extractor: frames go in byte by byte and
// every payload and end-of-frame transaction is checked against a built-in predictor.
// Depends on tpe_pkg and the RTL of the block; it needs nothing else.
module tb_top;
	import tpe_pkg::*;

	// The block is built with its default Ethernet header length.
	localparam int EthBytes = EthHdrBytesDefault;

	// Random part size in bytes, results before the long pressure hold, its length, watchdog limit.
	localparam int RandomBytes    = 250;
	localparam int PressureAfter  = 20;
	localparam int PressureCycles = 300;
	localparam int IdleLimit      = 2000;
	localparam int DrainCycles    = 10;

	// One input transaction: a frame byte and its end-of-frame mark.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} frame_item_t;

	// One output transaction as the predictor expects it.
	typedef struct packed {
		logic [7:0] data;
		logic       is_data;
		logic       is_final;
		status_t    status;
	} payload_result_t;

	typedef enum {
		FILL_RANDOM,
		FILL_ZERO,
		FILL_ONES
	} fill_t;

	typedef enum {
		FK_GOOD,
		FK_TRUNC,
		FK_SHORT_IP,
		FK_BAD_FLAGS,
		FK_SHORT_TCP,
		FK_NEG_LEN,
		FK_NOISE
	} frame_kind_t;

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       in_valid     = 1'b0;
	logic       in_stall;
	logic [7:0] frame_byte   = 8'h00;
	logic       frame_end    = 1'b0;
	logic       out_valid;
	logic       out_stall    = 1'b0;
	logic [7:0] data_byte;
	logic       is_data;
	logic       is_final;
	logic [2:0] frame_status;

	// Frame bytes not yet offered, and results predicted but not yet seen.
	frame_item_t     pending_q[$];
	payload_result_t expected_q[$];

	// Predictor copy of the parser state; all of it starts out cleared.
	logic [PosW-1:0] p_pos       = '0;
	logic [3:0]      p_ip_words  = '0;
	logic [15:0]     p_total_len = '0;
	logic [3:0]      p_tcp_words = '0;
	logic [15:0]     p_left      = '0;
	status_t         p_err       = ST_OK;

	int mismatches      = 0;
	int frames_queued   = 0;
	int bytes_sent      = 0;
	int results_checked = 0;
	int payload_seen    = 0;
	int status_seen[6];
	int idle_cycles     = 0;

	tcp_payload_extractor i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.frame_byte  (frame_byte),
		.frame_end   (frame_end),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.data_byte   (data_byte),
		.is_data     (is_data),
		.is_final    (is_final),
		.frame_status(frame_status)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Idle length for either side: mostly none, sometimes a short pause,
	// and now and then a long one.
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return 0;
		else if (r < 97)
			return $urandom_range(1, 2);
		else
			return $urandom_range(8, 30);
	endfunction

	// Steps the predictor by one accepted frame byte and queues the result
	// that the byte causes, if any. The header fields are picked up at fixed
	// offsets, and the first error of a frame freezes its status.
	task automatic predict_byte(input logic [7:0] b, input logic last);
		int unsigned     pos;
		int unsigned     tcp_start;
		int unsigned     hdr_end;
		int unsigned     ip_b;
		int unsigned     tcp_b;
		logic            emit;
		status_t         st;
		payload_result_t res;
		pos       = 32'(p_pos);
		tcp_start = EthBytes + p_ip_words * 4;
		hdr_end   = tcp_start + p_tcp_words * 4;
		emit      = 1'b0;
		st        = ST_OK;
		if (p_err == ST_OK) begin
			if (pos == EthBytes) begin
				p_ip_words = b[3:0];
				if (p_ip_words < MinHdrWords)
					p_err = ST_SHORT_IP;
			end else if (pos == EthBytes + IpLenHiOfs) begin
				p_total_len[15:8] = b;
			end else if (pos == EthBytes + IpLenLoOfs) begin
				p_total_len[7:0] = b;
			end else if (pos > EthBytes) begin
				if (pos == tcp_start + TcpOffsetOfs) begin
					p_tcp_words = b[7:4];
				end else if (pos == tcp_start + TcpFlagsOfs) begin
					// Flags first, then the TCP header length, then the sign
					// of the payload length.
					ip_b  = p_ip_words * 4;
					tcp_b = p_tcp_words * 4;
					if ((b & FlagMask) != FlagWant)
						p_err = ST_FLAGS;
					else if (p_tcp_words < MinHdrWords)
						p_err = ST_SHORT_TCP;
					else if (p_total_len < ip_b + tcp_b)
						p_err = ST_NEG_LEN;
					else
						p_left = 16'(p_total_len - ip_b - tcp_b);
				end else if (pos > tcp_start + TcpFlagsOfs && pos >= hdr_end &&
					p_left > 0) begin
					emit   = 1'b1;
					p_left = p_left - 16'd1;
				end
			end
		end
		if (last) begin
			st = p_err;
			// A clean frame that stops on or before its flags byte or before the
			// end of its payload counts as truncated.
			if (st == ST_OK && (pos <= EthBytes + p_ip_words * 4 + TcpFlagsOfs || p_left > 0))
				st = ST_TRUNC;
		end
		if (p_pos != '1)
			p_pos = p_pos + 1'b1;
		if (emit || last) begin
			res.data     = emit ? b : 8'h00;
			res.is_data  = emit;
			res.is_final = last;
			res.status   = st;
			expected_q.push_back(res);
		end
		if (last) begin
			p_pos       = '0;
			p_ip_words  = '0;
			p_total_len = '0;
			p_tcp_words = '0;
			p_left      = '0;
			p_err       = ST_OK;
		end
	endtask

	// Builds one frame and appends its bytes to the pending queue. The fill
	// gives the filler bytes; the IPv4 and TCP fields are then written over
	// them at their offsets, the TCP ones only where the IP header length
	// puts the TCP header behind it.
	task automatic queue_frame(input int unsigned ihl, input int unsigned tcp_words,
		input logic [7:0] flags, input int unsigned total_len,
		input int unsigned frame_len, input fill_t fill);
		int unsigned tcp_start;
		frame_item_t item;
		tcp_start = EthBytes + ihl * 4;
		for (int unsigned i = 0; i < frame_len; i++) begin
			case (fill)
				FILL_ZERO: item.data = 8'h00;
				FILL_ONES: item.data = 8'hFF;
				default:   item.data = 8'($urandom_range(0, 255));
			endcase
			if (i == EthBytes)
				item.data = {4'h4, ihl[3:0]};
			else if (i == EthBytes + IpLenHiOfs)
				item.data = total_len[15:8];
			else if (i == EthBytes + IpLenLoOfs)
				item.data = total_len[7:0];
			else if (ihl >= MinHdrWords && i == tcp_start + TcpOffsetOfs)
				item.data[7:4] = tcp_words[3:0];
			else if (ihl >= MinHdrWords && i == tcp_start + TcpFlagsOfs)
				item.data = flags;
			item.last = (i == frame_len - 1);
			pending_q.push_back(item);
		end
		frames_queued++;
	endtask

	// Stimulus. The directed frames come first, then random frames until the
	// random part holds enough bytes. About three fifths of the random frames
	// are well formed, so that most of them reach the payload; the rest are
	// broken in one way or another.
	initial begin : stimulus
		int unsigned ihl;
		int unsigned tw;
		int unsigned pay;
		int unsigned total;
		int unsigned pad;
		int unsigned len;
		int unsigned rand_start;
		int unsigned r;
		logic [7:0]  flags;
		frame_kind_t kind;

		// Single-byte frame, a frame ending on the IP header length byte, and a frame with a short IP header.
		queue_frame(5, 5, FlagWant, 40, 1, FILL_ONES);
		queue_frame(0, 5, FlagWant, 40, EthBytes + 1, FILL_ZERO);
		queue_frame(4, 5, FlagWant, 60, 40, FILL_RANDOM);
		// Clean frames: last byte is payload, largest headers with padding,
		// and two with an empty payload.
		queue_frame(5, 5, FlagWant, 43, EthBytes + 43, FILL_ZERO);
		queue_frame(15, 15, 8'hFC, 122, EthBytes + 126, FILL_ONES);
		queue_frame(5, 5, FlagWant, 40, EthBytes + 40, FILL_RANDOM);
		queue_frame(6, 7, FlagWant, 52, EthBytes + 58, FILL_RANDOM);
		// Flag rejections: FIN set, SYN set, ACK missing, PSH missing.
		queue_frame(5, 5, 8'h19, 50, EthBytes + 36, FILL_RANDOM);
		queue_frame(5, 5, 8'h1A, 50, EthBytes + 36, FILL_RANDOM);
		queue_frame(5, 5, 8'h08, 50, EthBytes + 36, FILL_RANDOM);
		queue_frame(5, 5, 8'h10, 50, EthBytes + 36, FILL_RANDOM);
		// Short TCP header; bad flags beat it, and it beats a negative length; then a negative length alone.
		queue_frame(5, 4, FlagWant, 50, EthBytes + 36, FILL_RANDOM);
		queue_frame(5, 4, 8'h1A, 50, EthBytes + 36, FILL_RANDOM);
		queue_frame(5, 3, FlagWant, 10, EthBytes + 36, FILL_RANDOM);
		queue_frame(5, 5, FlagWant, 39, EthBytes + 36, FILL_RANDOM);
		// Truncations: on the data offset byte, on the flags byte, and
		// in the middle of the payload.
		queue_frame(5, 5, FlagWant, 40, EthBytes + 33, FILL_RANDOM);
		queue_frame(5, 5, FlagWant, 40, EthBytes + 34, FILL_RANDOM);
		queue_frame(5, 5, FlagWant, 50, EthBytes + 45, FILL_RANDOM);

		rand_start = pending_q.size();
		while (pending_q.size() - rand_start < RandomBytes) begin
			r = $urandom_range(0, 99);
			if (r < 60)
				kind = FK_GOOD;
			else if (r < 70)
				kind = FK_TRUNC;
			else
				kind = frame_kind_t'($urandom_range(FK_SHORT_IP, FK_NOISE));
			ihl   = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 15) : $urandom_range(5, 6);
			tw    = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 15) : $urandom_range(5, 8);
			pay   = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200) : $urandom_range(0, 24);
			total = ihl * 4 + tw * 4 + pay;
			pad   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
			len   = EthBytes + total + pad;
			flags = (8'($urandom_range(0, 255)) & ~FlagMask) | FlagWant;
			case (kind)
				FK_TRUNC: begin
					len = $urandom_range(1, EthBytes + total - 1);
				end
				FK_SHORT_IP: begin
					ihl = $urandom_range(0, 4);
					len = $urandom_range(1, 80);
				end
				FK_BAD_FLAGS: begin
					do
						flags = 8'($urandom_range(0, 255));
					while ((flags & FlagMask) == FlagWant);
				end
				FK_SHORT_TCP: begin
					tw    = $urandom_range(0, 4);
					total = $urandom_range(0, 120);
				end
				FK_NEG_LEN: begin
					total = $urandom_range(0, ihl * 4 + tw * 4 - 1);
				end
				FK_NOISE: begin
					ihl   = $urandom_range(0, 15);
					tw    = $urandom_range(0, 15);
					flags = 8'($urandom_range(0, 255));
					total = $urandom_range(0, 16'hFFFF);
					len   = $urandom_range(1, 90);
				end
				default: begin
				end
			endcase
			queue_frame(ihl, tw, flags, total, len, FILL_RANDOM);
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Wait until every byte has gone in and every predicted result has
		// come out, then give the block a few more cycles to show anything
		// it should not.
		while (pending_q.size() != 0 || in_valid || expected_q.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		$display("covered %0d frames, %0d bytes in, %0d results checked (%0d payload bytes)",
			frames_queued, bytes_sent, results_checked, payload_seen);
		$display("frame ends by status ok/short_ip/flags/short_tcp/neg_len/trunc: %0d %0d %0d %0d %0d %0d",
			status_seen[ST_OK], status_seen[ST_SHORT_IP], status_seen[ST_FLAGS],
			status_seen[ST_SHORT_TCP], status_seen[ST_NEG_LEN], status_seen[ST_TRUNC]);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Driver. A byte counts as sent at an edge where valid is high and stall
	// is low; the predictor is stepped right there. A stalled byte is held
	// as it is. After each byte a random idle gap may follow, except inside
	// bursts, where bytes go back to back.
	always @(posedge clk or negedge arst_n) begin : driver
		frame_item_t item;
		int unsigned tx_gap;
		int unsigned tx_burst;
		if (!arst_n) begin
			in_valid   <= 1'b0;
			frame_byte <= 8'h00;
			frame_end  <= 1'b0;
			tx_gap     = 0;
			tx_burst   = 0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_byte(frame_byte, frame_end);
				bytes_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (pending_q.size() > 0) begin
					item = pending_q.pop_front();
					frame_byte <= item.data;
					frame_end  <= item.last;
					in_valid   <= 1'b1;
					if (tx_burst > 0) begin
						tx_burst--;
						tx_gap = 0;
					end else begin
						tx_gap = idle_len();
						if ($urandom_range(0, 15) == 0)
							tx_burst = $urandom_range(20, 80);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor. Every result transaction is compared with the oldest
	// prediction, field by field. The receiver stalls at random, runs
	// stall-free bursts, and once holds off for a long stretch so that the
	// output register stays full and the block has to stall its input.
	always @(posedge clk or negedge arst_n) begin : monitor
		payload_result_t want;
		int unsigned     rx_gap;
		int unsigned     stall_left;
		int unsigned     rx_burst;
		int unsigned     hold_left;
		logic            pressure_done;
		if (!arst_n) begin
			out_stall     <= 1'b0;
			stall_left    = 0;
			rx_burst      = 0;
			hold_left     = 0;
			pressure_done = 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					$error("unexpected result: data_byte %0h is_data %0b is_final %0b frame_status %0d",
						data_byte, is_data, is_final, frame_status);
					mismatches++;
				end else begin
					want = expected_q.pop_front();
					if (data_byte !== want.data) begin
						$error("data_byte: expected %0h, actual %0h", want.data, data_byte);
						mismatches++;
					end
					if (is_data !== want.is_data) begin
						$error("is_data: expected %0b, actual %0b", want.is_data, is_data);
						mismatches++;
					end
					if (is_final !== want.is_final) begin
						$error("is_final: expected %0b, actual %0b", want.is_final, is_final);
						mismatches++;
					end
					if (frame_status !== want.status) begin
						$error("frame_status: expected %0d, actual %0d", want.status, frame_status);
						mismatches++;
					end
					results_checked++;
					if (want.is_data)
						payload_seen++;
					if (want.is_final)
						status_seen[want.status]++;
				end
			end
			if (!pressure_done && results_checked >= PressureAfter) begin
				pressure_done = 1'b1;
				hold_left     = PressureCycles;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (rx_burst > 0) begin
				rx_burst--;
				out_stall <= 1'b0;
			end else begin
				rx_gap = idle_len();
				if (rx_gap == 0) begin
					out_stall <= 1'b0;
					if ($urandom_range(0, 19) == 0)
						rx_burst = $urandom_range(20, 80);
				end else begin
					out_stall  <= 1'b1;
					stall_left = rx_gap - 1;
				end
			end
		end
	end

	// Watchdog: ends the run when neither channel has moved a transaction
	// for far longer than the longest hold-off of either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IdleLimit) begin
				$display("status: fail");
				$finish;
			end
		end
	end

endmodule

FILE: sim.f
rtl/tpe_pkg.sv
rtl/tpe_parse.sv
rtl/tcp_payload_extractor.sv
rtl/tpe_checker.sv
verif/tb_top.sv
